[design/lcdns_pkg.sv]
// Package for the character-LCD nibble sequencer.
// Message kinds, LCD command constants and the run descriptor type.
// No dependencies.
package lcdns_pkg;

  // Message kinds carried in the kind field; code 7 is unused
  localparam logic [2:0] KIND_START  = 3'd0;
  localparam logic [2:0] KIND_DDRAM  = 3'd1;
  localparam logic [2:0] KIND_CGRAM  = 3'd2;
  localparam logic [2:0] KIND_MASKED = 3'd3;
  localparam logic [2:0] KIND_OPS    = 3'd4;
  localparam logic [2:0] KIND_CHARS  = 3'd5;
  localparam logic [2:0] KIND_TICK   = 3'd6;

  // Register choice for masked updates
  localparam logic [7:0] REG_CONTROL = 8'd0;
  localparam logic [7:0] REG_ENTRY   = 8'd1;

  // Op types for the two-op message
  localparam logic [7:0] OP_CMD  = 8'd1;
  localparam logic [7:0] OP_DATA = 8'd2;

  // Register-select values
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // LCD commands and bit fields
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
  localparam logic [7:0] CGRAM_ADDR_MASK = 8'h3F;
  localparam logic [7:0] CMD_FUNC_4BIT = 8'h20;
  localparam logic [7:0] CMD_FUNC_2LINE = 8'h28;
  localparam logic [7:0] CMD_DISP_CTRL = 8'h08;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h04;
  localparam logic [7:0] CMD_HOME = 8'h02;

  // Register reset values
  localparam logic [7:0] DISP_CTRL_RESET = 8'h04;
  localparam logic [7:0] ENTRY_MODE_RESET = 8'h02;

  // Power-on sequence step counter
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_DONE = 4'd8;

  // Run descriptor: up to five bytes with their register-select bits
  localparam int MAX_BYTES = 5;
  localparam int BYTE_IDX_W = $clog2(MAX_BYTES);
  localparam int NBYTES_W = $clog2(MAX_BYTES + 1);

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] data;
    logic [MAX_BYTES-1:0]      rs;
    logic [NBYTES_W-1:0]       nbytes;
  } run_t;

endpackage

[design/lcdns_if.sv]
// Handshake channels of the character-LCD nibble sequencer.
// Message channel in, nibble channel out; depends on nothing.
interface lcdns_msg_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] arg0;
  logic [7:0] arg1;
  logic [7:0] arg2;
  logic [7:0] arg3;
  logic [7:0] arg4;

  modport source (output valid, kind, arg0, arg1, arg2, arg3, arg4, input ready);
  modport sink   (input valid, kind, arg0, arg1, arg2, arg3, arg4, output ready);
endinterface

interface lcdns_nib_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, reg_select, nibble, last, input ready);
  modport sink   (input valid, reg_select, nibble, last, output ready);
endinterface

[design/char_lcd_nibble_sequencer.sv]
// Character-LCD 4-bit sequencer top level: front end, run queue, serializer.
// Depends on lcdns_pkg, lcdns_if, lcdns_front, lcdns_queue, lcdns_back.
//
// Each message becomes a run of nibble writes for a 4-bit LCD bus, every
// byte high nibble first with reg_select low for commands, high for data;
// last marks the final nibble of a run and messages that send nothing
// (start, some ticks, unknown choices or kinds) produce no nibble at all.
// The output delivers one nibble per cycle while the receiver keeps ready high,
// two nibbles per byte, so the serializer sets the sustained rate.
// The front end takes a message whenever the run queue
// (QUEUE_DEPTH runs) has room, so messages can arrive back to back while
// earlier runs are still being shifted out. Ticks are ignored until a start
// message begins the six-command power-on sequence.
module char_lcd_nibble_sequencer import lcdns_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lcdns_msg_if.sink   msg,
  lcdns_nib_if.source nib
);

  logic push, full, pop, head_valid;
  run_t push_run, head_run;

  lcdns_front u_front (
    .clk      (clk),
    .rst      (rst),
    .msg      (msg),
    .push     (push),
    .push_run (push_run),
    .full     (full)
  );

  lcdns_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_run   (push_run),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run)
  );

  lcdns_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_run   (head_run),
    .pop        (pop),
    .nib        (nib)
  );

endmodule

[design/lcdns_front.sv]
// Front end: accepts messages, updates the LCD shadow registers and the
// power-on step, and builds a byte run descriptor. Uses lcdns_pkg, lcdns_if.
module lcdns_front import lcdns_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  lcdns_msg_if.sink  msg,
  output logic       push,
  output run_t       push_run,
  input  logic       full
);

  logic [STEP_W-1:0] init_step, init_step_next;
  logic [7:0]        display_control, display_control_next;
  logic [7:0]        entry_mode, entry_mode_next;
  logic              accept;
  logic              op0_ok, op1_ok;
  run_t              run;

  assign msg.ready = !full;
  assign accept    = msg.valid && msg.ready;

  // Valid op types in the two-op message
  assign op0_ok = (msg.arg0 == OP_CMD) || (msg.arg0 == OP_DATA);
  assign op1_ok = (msg.arg2 == OP_CMD) || (msg.arg2 == OP_DATA);

  // Classify the message into a byte run and the next register values
  always_comb begin
    run                  = '0;
    init_step_next       = init_step;
    display_control_next = display_control;
    entry_mode_next      = entry_mode;
    unique case (msg.kind) inside
      KIND_START: begin
        display_control_next = DISP_CTRL_RESET;
        entry_mode_next      = ENTRY_MODE_RESET;
        init_step_next       = '0;
      end
      KIND_DDRAM, KIND_CGRAM: begin
        run.data[0] = (msg.kind == KIND_DDRAM) ? (CMD_SET_DDRAM | msg.arg0)
                                               : (CMD_SET_CGRAM | (msg.arg0 & CGRAM_ADDR_MASK));
        run.data[1] = msg.arg1;
        run.data[2] = msg.arg2;
        run.data[3] = msg.arg3;
        run.data[4] = msg.arg4;
        run.rs      = {RS_DATA, RS_DATA, RS_DATA, RS_DATA, RS_CMD};
        run.nbytes  = NBYTES_W'(MAX_BYTES);
      end
      KIND_MASKED: begin
        if (msg.arg0 == REG_CONTROL) begin
          display_control_next = (display_control & msg.arg1) | msg.arg2;
          run.data[0] = display_control_next | CMD_DISP_CTRL;
          run.nbytes  = NBYTES_W'(1);
        end else if (msg.arg0 == REG_ENTRY) begin
          entry_mode_next = (entry_mode & msg.arg1) | msg.arg2;
          run.data[0] = entry_mode_next | CMD_ENTRY_MODE;
          run.nbytes  = NBYTES_W'(1);
        end
      end
      KIND_OPS: begin
        // Skipped ops are squeezed out so the run stays packed
        run.data[0] = op0_ok ? msg.arg1 : msg.arg3;
        run.rs[0]   = op0_ok ? (msg.arg0 == OP_DATA) : (msg.arg2 == OP_DATA);
        run.data[1] = msg.arg3;
        run.rs[1]   = (msg.arg2 == OP_DATA);
        run.nbytes  = NBYTES_W'(op0_ok) + NBYTES_W'(op1_ok);
      end
      KIND_CHARS: begin
        run.data   = {msg.arg4, msg.arg3, msg.arg2, msg.arg1, msg.arg0};
        run.rs     = '1;
        run.nbytes = NBYTES_W'(MAX_BYTES);
      end
      KIND_TICK: begin
        run.nbytes = NBYTES_W'(1);
        case (init_step)
          4'd0: run.data[0] = CMD_FUNC_4BIT;
          4'd1: run.data[0] = CMD_FUNC_2LINE;
          4'd2: run.data[0] = display_control | CMD_DISP_CTRL;
          4'd3: run.data[0] = entry_mode | CMD_ENTRY_MODE;
          4'd4: run.data[0] = CMD_SET_DDRAM;
          4'd5: run.data[0] = CMD_HOME;
          default: run.nbytes = '0;
        endcase
        if (init_step < STEP_DONE) begin
          init_step_next = init_step + STEP_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Empty runs never enter the queue
  assign push     = accept && (run.nbytes != '0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_step       <= STEP_DONE;
      display_control <= DISP_CTRL_RESET;
      entry_mode      <= ENTRY_MODE_RESET;
    end else if (accept) begin
      init_step       <= init_step_next;
      display_control <= display_control_next;
      entry_mode      <= entry_mode_next;
    end
  end

endmodule

[design/lcdns_queue.sv]
// Short run queue between front end and nibble serializer.
// Circular buffer of run descriptors; uses lcdns_pkg.
module lcdns_queue import lcdns_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t push_run,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output run_t head_run
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_run   = store[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_run;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[design/lcdns_back.sv]
// Back end: serializes the head run into nibbles, high nibble first,
// through a registered output. Uses lcdns_pkg, lcdns_if.
module lcdns_back import lcdns_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  run_t         head_run,
  output logic         pop,
  lcdns_nib_if.source  nib
);

  logic [BYTE_IDX_W-1:0] idx;
  logic                  half;
  logic                  emit;
  logic                  final_nib;
  logic [7:0]            cur_byte;

  assign emit      = head_valid && (!nib.valid || nib.ready);
  assign cur_byte  = head_run.data[idx];
  assign final_nib = half && (NBYTES_W'(idx) == head_run.nbytes - NBYTES_W'(1));
  assign pop       = emit && final_nib;

  // Byte index and nibble half
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      half <= 1'b0;
    end else if (emit) begin
      if (final_nib) begin
        idx <= '0;
      end else if (half) begin
        idx <= idx + BYTE_IDX_W'(1);
      end
      half <= !half;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      nib.valid <= 1'b0;
    end else if (emit) begin
      nib.valid <= 1'b1;
    end else if (nib.ready) begin
      nib.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      nib.reg_select <= head_run.rs[idx];
      nib.nibble     <= half ? cur_byte[3:0] : cur_byte[7:4];
      nib.last       <= final_nib;
    end
  end

endmodule

[design/lcdns_checker.sv]
// Port-level checks for the character-LCD nibble sequencer.
// Bound to char_lcd_nibble_sequencer; no package dependency.
module lcdns_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_rs,
  input logic out_last
);

  logic odd_nib;
  logic first_rs;

  // Track which half of a byte the next delivered nibble is
  always_ff @(posedge clk) begin
    if (rst) begin
      odd_nib <= 1'b0;
    end else if (out_valid && out_ready) begin
      odd_nib <= !odd_nib;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready && !odd_nib) begin
      first_rs <= out_rs;
    end
  end

  // Reset empties the output stage
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("nibble valid after reset");

  // A stalled nibble stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("nibble withdrawn while stalled");

  // A run always ends on the low nibble of a byte
  a_last_on_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |-> odd_nib)
    else $error("last flag on a high nibble");

  // Both nibbles of a byte carry the same register select
  a_rs_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && odd_nib |-> out_rs == first_rs)
    else $error("register select changed within a byte");

endmodule

bind char_lcd_nibble_sequencer lcdns_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (nib.valid),
  .out_ready (nib.ready),
  .out_rs    (nib.reg_select),
  .out_last  (nib.last)
);

[tb/sv/tb_char_lcd_nibble_sequencer.sv]
`timescale 1ns / 100ps
// Testbench for char_lcd_nibble_sequencer: drives LCD messages, predicts the nibble runs.
// Random idling on both sides and one long output hold-off.
// Depends on lcdns_pkg, lcdns_if and the design top level.
module tb_char_lcd_nibble_sequencer;
  import lcdns_pkg::*;

  // Kind code with no meaning in the block
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int MSG_COUNT = 470;
  localparam int QUIET_TAIL = 60;
  localparam int HOLD_AT_MSG = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] a0;
    logic [7:0] a1;
    logic [7:0] a2;
    logic [7:0] a3;
    logic [7:0] a4;
  } lcd_msg_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
  } lcd_nib_t;

  logic clk;
  logic rst;

  lcdns_msg_if msg_ch ();
  lcdns_nib_if nib_ch ();

  char_lcd_nibble_sequencer u_top (
    .clk (clk),
    .rst (rst),
    .msg (msg_ch),
    .nib (nib_ch)
  );

  lcd_msg_t msg_backlog[$];
  lcd_nib_t lcd_nibbles_due[$];
  lcd_msg_t on_offer;
  int msgs_taken;
  int msgs_total;
  int mismatches;
  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_done;

  // Shadow of the block state
  logic [STEP_W-1:0] pwr_step = STEP_DONE;
  logic [7:0] disp_ctrl_q = DISP_CTRL_RESET;
  logic [7:0] entry_q = ENTRY_MODE_RESET;

  // Turns one message into its nibble run and updates the shadow state
  task automatic sequence_message(input lcd_msg_t m);
    logic [8:0] run_bytes[$];
    lcd_nib_t n;
    case (m.kind) inside
      KIND_START: begin
        disp_ctrl_q = DISP_CTRL_RESET;
        entry_q = ENTRY_MODE_RESET;
        pwr_step = '0;
      end
      KIND_DDRAM, KIND_CGRAM: begin
        if (m.kind == KIND_DDRAM) run_bytes.push_back({RS_CMD, CMD_SET_DDRAM | m.a0});
        else run_bytes.push_back({RS_CMD, CMD_SET_CGRAM | (m.a0 & CGRAM_ADDR_MASK)});
        run_bytes.push_back({RS_DATA, m.a1});
        run_bytes.push_back({RS_DATA, m.a2});
        run_bytes.push_back({RS_DATA, m.a3});
        run_bytes.push_back({RS_DATA, m.a4});
      end
      KIND_MASKED: begin
        if (m.a0 == REG_CONTROL) begin
          disp_ctrl_q = (disp_ctrl_q & m.a1) | m.a2;
          run_bytes.push_back({RS_CMD, disp_ctrl_q | CMD_DISP_CTRL});
        end else if (m.a0 == REG_ENTRY) begin
          entry_q = (entry_q & m.a1) | m.a2;
          run_bytes.push_back({RS_CMD, entry_q | CMD_ENTRY_MODE});
        end
      end
      KIND_OPS: begin
        if (m.a0 == OP_CMD) run_bytes.push_back({RS_CMD, m.a1});
        else if (m.a0 == OP_DATA) run_bytes.push_back({RS_DATA, m.a1});
        if (m.a2 == OP_CMD) run_bytes.push_back({RS_CMD, m.a3});
        else if (m.a2 == OP_DATA) run_bytes.push_back({RS_DATA, m.a3});
      end
      KIND_CHARS: begin
        run_bytes.push_back({RS_DATA, m.a0});
        run_bytes.push_back({RS_DATA, m.a1});
        run_bytes.push_back({RS_DATA, m.a2});
        run_bytes.push_back({RS_DATA, m.a3});
        run_bytes.push_back({RS_DATA, m.a4});
      end
      KIND_TICK: begin
        // power-on sequence; steps 6 and 7 are silent
        case (pwr_step)
          4'd0: run_bytes.push_back({RS_CMD, CMD_FUNC_4BIT});
          4'd1: run_bytes.push_back({RS_CMD, CMD_FUNC_2LINE});
          4'd2: run_bytes.push_back({RS_CMD, disp_ctrl_q | CMD_DISP_CTRL});
          4'd3: run_bytes.push_back({RS_CMD, entry_q | CMD_ENTRY_MODE});
          4'd4: run_bytes.push_back({RS_CMD, CMD_SET_DDRAM});
          4'd5: run_bytes.push_back({RS_CMD, CMD_HOME});
          default: ;
        endcase
        if (pwr_step < STEP_DONE) pwr_step = pwr_step + 1'b1;
      end
      default: ;
    endcase
    // high nibble first; last only on the final nibble of the run
    for (int i = 0; i < run_bytes.size(); i++) begin
      n.rs = run_bytes[i][8];
      n.nib = run_bytes[i][7:4];
      n.last = 1'b0;
      lcd_nibbles_due.push_back(n);
      n.nib = run_bytes[i][3:0];
      n.last = (i == run_bytes.size() - 1);
      lcd_nibbles_due.push_back(n);
    end
  endtask

  function automatic lcd_msg_t make_msg(logic [2:0] k, logic [7:0] a0, logic [7:0] a1,
                                        logic [7:0] a2, logic [7:0] a3, logic [7:0] a4);
    lcd_msg_t m;
    m.kind = k;
    m.a0 = a0;
    m.a1 = a1;
    m.a2 = a2;
    m.a3 = a3;
    m.a4 = a4;
    return m;
  endfunction

  // Mostly valid op types, sometimes junk
  function automatic logic [7:0] random_op_type();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return OP_CMD;
    if (r < 8) return OP_DATA;
    return 8'($urandom);
  endfunction

  function automatic lcd_msg_t random_msg();
    lcd_msg_t m;
    int pick;
    m = make_msg(3'd0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 3) m.kind = KIND_START;
    else if (pick < 6) m.kind = KIND_UNUSED;
    else if (pick < 14) m.kind = KIND_TICK;
    else m.kind = 3'($urandom_range(KIND_DDRAM, KIND_CHARS));
    if (m.kind == KIND_MASKED) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) m.a0 = REG_CONTROL;
      else if (pick < 8) m.a0 = REG_ENTRY;
    end else if (m.kind == KIND_OPS) begin
      m.a0 = random_op_type();
      m.a2 = random_op_type();
    end
    return m;
  endfunction

  // Idling is on in stretches and off near the end
  function automatic bit jitter_on();
    return (msg_backlog.size() > QUIET_TAIL) && ((msgs_taken % 150) < 100);
  endfunction

  // Clock, reset and known input levels from time zero
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    msg_ch.valid = 1'b0;
    msg_ch.kind = '0;
    msg_ch.arg0 = '0;
    msg_ch.arg1 = '0;
    msg_ch.arg2 = '0;
    msg_ch.arg3 = '0;
    msg_ch.arg4 = '0;
    nib_ch.ready = 1'b0;
    fork
      forever #4 clk = ~clk;
      begin
        repeat (10) @(posedge clk);
        rst <= 1'b0;
      end
    join_none
  end

  // Stimulus: directed messages, then random ones
  initial begin
    int ticks;
    // ticks before any start are ignored; unknown kind does nothing
    msg_backlog.push_back(make_msg(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    msg_backlog.push_back(make_msg(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    msg_backlog.push_back(make_msg(KIND_START, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    msg_backlog.push_back(make_msg(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    msg_backlog.push_back(make_msg(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // control register changed mid-sequence, high bits included
    msg_backlog.push_back(make_msg(KIND_MASKED, REG_CONTROL, 8'h00, 8'hF3, 8'h00, 8'h00));
    repeat (7)
      msg_backlog.push_back(make_msg(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    msg_backlog.push_back(make_msg(KIND_DDRAM, 8'hFF, 8'h00, 8'hFF, 8'h5A, 8'hA5));
    msg_backlog.push_back(make_msg(KIND_CGRAM, 8'hFF, 8'hFF, 8'h00, 8'h0F, 8'hF0));
    msg_backlog.push_back(make_msg(KIND_MASKED, REG_ENTRY, 8'hFF, 8'hFF, 8'h00, 8'h00));
    msg_backlog.push_back(make_msg(KIND_MASKED, 8'h05, 8'h00, 8'hFF, 8'h00, 8'h00));
    msg_backlog.push_back(make_msg(KIND_OPS, OP_CMD, 8'hC3, OP_DATA, 8'h3C, 8'h00));
    msg_backlog.push_back(make_msg(KIND_OPS, 8'h00, 8'hFF, 8'h03, 8'hFF, 8'hFF));
    msg_backlog.push_back(make_msg(KIND_OPS, OP_DATA, 8'h00, 8'hFF, 8'h11, 8'h00));
    msg_backlog.push_back(make_msg(KIND_CHARS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    msg_backlog.push_back(make_msg(KIND_CHARS, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // random part: power-on sequences with traffic mixed in, plus loose messages
    while (msg_backlog.size() < MSG_COUNT) begin
      if ($urandom_range(0, 99) < 8) begin
        msg_backlog.push_back(make_msg(KIND_START, 8'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom), 8'($urandom)));
        ticks = $urandom_range(8, 10);
        for (int i = 0; i < ticks; i++) begin
          if ($urandom_range(0, 2) == 0) msg_backlog.push_back(random_msg());
          msg_backlog.push_back(make_msg(KIND_TICK, 8'($urandom), 8'($urandom),
                                         8'($urandom), 8'($urandom), 8'($urandom)));
        end
      end else begin
        msg_backlog.push_back(random_msg());
      end
    end
    msgs_total = msg_backlog.size();

    @(negedge rst);
    while (msgs_taken != msgs_total) @(posedge clk);
    while (lcd_nibbles_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("char_lcd_nibble_sequencer verification clean");
    else $display("char_lcd_nibble_sequencer verification failed");
    $finish;
  end

  // Run limit
  initial begin
    #(5_000_000);
    $display("char_lcd_nibble_sequencer verification failed");
    $finish;
  end

  // Message driver
  always @(posedge clk) begin
    if (rst) begin
      msg_ch.valid <= 1'b0;
      msg_ch.kind <= '0;
      msg_ch.arg0 <= '0;
      msg_ch.arg1 <= '0;
      msg_ch.arg2 <= '0;
      msg_ch.arg3 <= '0;
      msg_ch.arg4 <= '0;
      gap_left <= 0;
      msgs_taken <= 0;
    end else begin
      if (msg_ch.valid && msg_ch.ready) begin
        sequence_message(on_offer);
        msgs_taken <= msgs_taken + 1;
      end
      if (!msg_ch.valid || msg_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          msg_ch.valid <= 1'b0;
        end else if (msg_backlog.size() == 0) begin
          msg_ch.valid <= 1'b0;
        end else if (jitter_on() && $urandom_range(0, 4) == 0) begin
          gap_left <= $urandom_range(0, 7);
          msg_ch.valid <= 1'b0;
        end else begin
          on_offer = msg_backlog.pop_front();
          msg_ch.valid <= 1'b1;
          msg_ch.kind <= on_offer.kind;
          msg_ch.arg0 <= on_offer.a0;
          msg_ch.arg1 <= on_offer.a1;
          msg_ch.arg2 <= on_offer.a2;
          msg_ch.arg3 <= on_offer.a3;
          msg_ch.arg4 <= on_offer.a4;
        end
      end
    end
  end

  // One long output hold-off so the run queue fills and the input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && msgs_taken >= HOLD_AT_MSG) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Nibble monitor and checker, with receiver stalls
  always @(posedge clk) begin
    lcd_nib_t want;
    if (rst) begin
      nib_ch.ready <= 1'b0;
      stall_left <= 0;
      mismatches <= 0;
    end else begin
      if (nib_ch.valid && nib_ch.ready) begin
        if (lcd_nibbles_due.size() == 0) begin
          $display("%0t: unexpected nibble: rs=%0d nibble=%h last=%0d", $time,
                   nib_ch.reg_select, nib_ch.nibble, nib_ch.last);
          mismatches <= mismatches + 1;
        end else begin
          want = lcd_nibbles_due.pop_front();
          if (nib_ch.reg_select !== want.rs || nib_ch.nibble !== want.nib ||
              nib_ch.last !== want.last)
            mismatches <= mismatches + 1;
          if (nib_ch.reg_select !== want.rs)
            $display("%0t: reg_select mismatch: expected %0d actual %0d", $time,
                     want.rs, nib_ch.reg_select);
          if (nib_ch.nibble !== want.nib)
            $display("%0t: nibble mismatch: expected %h actual %h", $time,
                     want.nib, nib_ch.nibble);
          if (nib_ch.last !== want.last)
            $display("%0t: last mismatch: expected %0d actual %0d", $time,
                     want.last, nib_ch.last);
        end
      end
      if (hold_left > 0) begin
        nib_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        nib_ch.ready <= 1'b0;
      end else if (jitter_on() && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 7);
        nib_ch.ready <= 1'b0;
      end else begin
        nib_ch.ready <= 1'b1;
      end
    end
  end

endmodule
